// ===== rtl/core/fth_pkg.sv =====
// Shared types and constants for the frame time histogram.
// Holds the opcodes, register map, reset values and the divider request/response structs.
// No dependencies.
package fth_pkg;

    // Default number of histogram slots.
    localparam int SLOTS_DEF = 16;

    // Register map of the configuration port.
    localparam int          ADDR_W     = 3;
    localparam logic        REG_STEP   = 1'b0;
    localparam logic [19:0] STEP_RESET = 20'd15000;

    // Item opcodes.
    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REPORT = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    // Shared divider geometry: 40-bit dividend, 32-bit divisor, 8-bit quotient.
    localparam int DIV_NUM_W = 40;
    localparam int DIV_DEN_W = 32;
    localparam int DIV_QUO_W = 8;

    localparam logic [7:0] LEVEL_MAX = 8'd255;
    localparam logic [7:0] LEVEL_MIN = 8'd1;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic                 ovf;
        logic [DIV_QUO_W-1:0] quo;
    } div_rsp_t;

endpackage

// ===== rtl/core/fth_div.sv =====
// Iterative restoring divider with an 8-bit quotient and an overflow flag.
// One quotient bit per cycle; depends on fth_pkg for the request/response structs.
module fth_div
    import fth_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic                 ovf_reg,  ovf_next;
    logic [2:0]           cnt_reg,  cnt_next;
    logic [DIV_NUM_W-1:0] rem_reg,  rem_next;
    logic [DIV_NUM_W-1:0] dsh_reg,  dsh_next;
    logic [DIV_QUO_W-1:0] quo_reg,  quo_next;
    logic                 take;

    // Trial subtraction of the shifted divisor.
    assign take = (rem_reg >= dsh_reg);

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        if (req.start) begin
            // The quotient overflows 8 bits when num is at least den * 256.
            busy_next = 1'b1;
            ovf_next  = (req.num >= {req.den, 8'b0});
            cnt_next  = 3'd7;
            rem_next  = req.num;
            dsh_next  = {1'b0, req.den, 7'b0};
            quo_next  = '0;
        end else if (busy_reg) begin
            if (take) begin
                rem_next = rem_reg - dsh_reg;
            end
            quo_next = {quo_reg[DIV_QUO_W-2:0], take};
            dsh_next = {1'b0, dsh_reg[DIV_NUM_W-1:1]};
            cnt_next = cnt_reg - 3'd1;
            if (cnt_reg == 3'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge aclk) begin
        ovf_reg <= ovf_next;
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.ovf  = ovf_reg;
    assign rsp.quo  = quo_reg;

endmodule

// ===== rtl/core/frame_time_histogram.sv =====
// Top level of the frame time histogram: slot memory, sequencer and configuration port.
// Depends on fth_pkg and instantiates fth_div.
//
// Usage: one input channel (s_valid/s_ready) carries items with an opcode and a frame
// time. An add transfer rounds the frame time to the nearest slot of width step_us
// (clamped to the last slot) and increments that slot and the running total; it holds
// the input through 8 steps of the shared divider, a step that takes the quotient and
// reads the memory, and a write back, so no new item is taken until it is done. A clear
// transfer zeroes all counts and the total. A report transfer streams SLOTS result
// transfers on the m_ channel, slot 0 first, m_last on the final one. Each slot takes
// a step to start the divider on 255*count/total, eight divider steps, a step to take
// the level and a step to load the result register, and a report holds the input
// until the result register is loaded with the last slot. The result register parts
// the two sides: the next slot is computed while a result waits, and when the
// receiver stalls the sequencer holds until the register is free. s_ready is high
// only while no item is in progress. After reset all counts and the total read as
// zero (per-slot valid bits, no clearing pass) and step_us is 15000. step_us is
// written over the APB port at byte address 0; the user must write it only while
// the block is idle, as the block itself does not enforce this.
module frame_time_histogram
    import fth_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic              aclk,
    input  logic              aresetn,
    // Configuration port.
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // Input channel.
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_opcode,
    input  logic [21:0]       s_frame_time_us,
    // Result channel.
    output logic              m_valid,
    input  logic              m_ready,
    output logic [3:0]        m_slot_index,
    output logic [31:0]       m_raw_count,
    output logic [7:0]        m_packed_level,
    output logic              m_last
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_ADIV   = 6'b000010,
        ST_AWR    = 6'b000100,
        ST_RSTART = 6'b001000,
        ST_RDIV   = 6'b010000,
        ST_ROUT   = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [19:0]       step_reg;
    logic [31:0]       total_reg, total_next;
    logic [SLOTS-1:0]  vld_reg, vld_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [IW-1:0]     slot_reg, slot_next;
    logic [31:0]       count_reg, count_next;
    logic [7:0]        lvl_reg, lvl_next;

    logic              m_valid_reg, m_valid_next;
    logic [3:0]        m_slot_reg;
    logic [31:0]       m_count_reg;
    logic [7:0]        m_lvl_reg;
    logic              m_last_reg;

    // Slot memory.
    logic [31:0]       mem [SLOTS];
    logic              mem_re, mem_we;
    logic [IW-1:0]     mem_ra;
    logic [31:0]       mem_wd;
    logic [31:0]       rd_data_reg;
    logic              rd_vld_reg;

    div_req_t          div_req;
    div_rsp_t          div_rsp;

    logic              s_acc;
    logic              cfg_wr;
    logic [19:0]       step_eff;
    logic [IW-1:0]     slot_c;
    logic [31:0]       count_c;
    logic              idx_last;
    logic              out_load;
    logic [7:0]        idx_ext;

    // Configuration port: one register, always ready.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_STEP);
    assign prdata = (paddr[2] == REG_STEP) ? {12'b0, step_reg} : 32'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_RESET;
        end else if (cfg_wr) begin
            step_reg <= pwdata[19:0];
        end
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_acc    = s_valid && s_ready;
    assign step_eff = (step_reg == 20'd0) ? 20'd1 : step_reg;

    // Slot from the divider quotient, clamped to the last slot.
    always_comb begin
        if (div_rsp.ovf || (div_rsp.quo >= 8'(SLOTS))) begin
            slot_c = IW'(SLOTS - 1);
        end else begin
            slot_c = div_rsp.quo[IW-1:0];
        end
    end

    // A slot that was never written since reset or clear reads as zero.
    assign count_c  = rd_vld_reg ? rd_data_reg : 32'd0;
    assign idx_last = (idx_reg == IW'(SLOTS - 1));
    assign out_load = (state_reg == ST_ROUT) && (!m_valid_reg || m_ready);
    assign idx_ext  = 8'(idx_reg);

    // Sequencer.
    always_comb begin
        state_next   = state_reg;
        total_next   = total_reg;
        vld_next     = vld_reg;
        idx_next     = idx_reg;
        slot_next    = slot_reg;
        count_next   = count_reg;
        lvl_next     = lvl_reg;
        m_valid_next = m_valid_reg;
        mem_re       = 1'b0;
        mem_ra       = idx_reg;
        mem_we       = 1'b0;
        mem_wd       = count_c + 32'd1;
        div_req      = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    case (s_opcode)
                        OP_ADD: begin
                            // Nearest slot: (2t + step) / (2 step).
                            div_req.start = 1'b1;
                            div_req.num   = {17'b0, s_frame_time_us, 1'b0}
                                          + {20'b0, step_eff};
                            div_req.den   = {11'b0, step_eff, 1'b0};
                            state_next    = ST_ADIV;
                        end
                        OP_REPORT: begin
                            idx_next   = '0;
                            mem_re     = 1'b1;
                            mem_ra     = '0;
                            state_next = ST_RSTART;
                        end
                        OP_CLEAR: begin
                            vld_next   = '0;
                            total_next = 32'd0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ADIV: begin
                if (div_rsp.done) begin
                    slot_next  = slot_c;
                    mem_re     = 1'b1;
                    mem_ra     = slot_c;
                    state_next = ST_AWR;
                end
            end
            ST_AWR: begin
                // Write back the incremented count; counts and total wrap.
                mem_we            = 1'b1;
                vld_next[slot_reg] = 1'b1;
                total_next        = total_reg + 32'd1;
                state_next        = ST_IDLE;
            end
            ST_RSTART: begin
                // Level = 255 * count / total, total of zero taken as one.
                count_next    = count_c;
                div_req.start = 1'b1;
                div_req.num   = {count_c, 8'b0} - {8'b0, count_c};
                div_req.den   = (total_reg == 32'd0) ? 32'd1 : total_reg;
                state_next    = ST_RDIV;
            end
            ST_RDIV: begin
                if (div_rsp.done) begin
                    if (div_rsp.ovf) begin
                        lvl_next = LEVEL_MAX;
                    end else if ((div_rsp.quo == 8'd0) && (count_reg != 32'd0)) begin
                        lvl_next = LEVEL_MIN;
                    end else begin
                        lvl_next = div_rsp.quo;
                    end
                    state_next = ST_ROUT;
                end
            end
            ST_ROUT: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    if (idx_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + IW'(1);
                        mem_re     = 1'b1;
                        mem_ra     = idx_reg + IW'(1);
                        state_next = ST_RSTART;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            total_reg   <= 32'd0;
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            vld_reg     <= vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Working and result payload registers.
    always_ff @(posedge aclk) begin
        idx_reg   <= idx_next;
        slot_reg  <= slot_next;
        count_reg <= count_next;
        lvl_reg   <= lvl_next;
        if (out_load) begin
            m_slot_reg  <= idx_ext[3:0];
            m_count_reg <= count_reg;
            m_lvl_reg   <= lvl_reg;
            m_last_reg  <= idx_last;
        end
    end

    // Slot memory with a registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[slot_reg] <= mem_wd;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_ra];
            rd_vld_reg  <= vld_reg[mem_ra];
        end
    end

    fth_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign m_valid        = m_valid_reg;
    assign m_slot_index   = m_slot_reg;
    assign m_raw_count    = m_count_reg;
    assign m_packed_level = m_lvl_reg;
    assign m_last         = m_last_reg;

    // The divider is never restarted while it is still working.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // A result appears only when the sequencer hands over a finished slot.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_ROUT))
        else $error("result raised outside the output step");

    // The final result of a report always carries the last slot.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last) |-> (m_slot_index == 4'(SLOTS - 1)))
        else $error("last flag on the wrong slot");

    // A clear transfer empties every slot and the total.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && (s_opcode == OP_CLEAR)) |=> ((vld_reg == '0) && (total_reg == 32'd0)))
        else $error("clear did not empty the histogram");

endmodule
